/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");

// expression never true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

/* hdl/ptvs_pkg.sv */
// ----------------------------------------------------------------------------
// ptvs_pkg
// Shared widths, constants and lane control type for the velocity smoother.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptvs_pkg;

	localparam int POS_W        = 32;
	localparam int STAMP_W      = 32;
	localparam int CFG_W        = 20;
	localparam int N_AXES       = 3;
	localparam int AVG_TAPS_DEF = 5;

	// quotient/numerator width of the divider, even for the radix-4 step
	localparam int NUM_W = 54;
	localparam int DEN_W = 32;

	localparam logic [CFG_W-1:0] MIN_STEP_RESET = CFG_W'(10000);
	localparam logic [CFG_W-1:0] US_PER_S       = CFG_W'(1000000);

	typedef struct packed {
		logic start;
		logic prime;
	} lane_ctl_t;

endpackage

`default_nettype wire

/* hdl/ptvs_div.sv */
// ----------------------------------------------------------------------------
// ptvs_div
// Unsigned restoring divider, two quotient bits per cycle, rounds half up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ptvs_div #(
	parameter int NW          = ptvs_pkg::NUM_W,
	parameter int DW          = ptvs_pkg::DEN_W,
	parameter int SHORT_STEPS = 18
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	input  wire           short_sel,
	input  wire  [NW-1:0] num,
	input  wire  [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	import ptvs_pkg::*;

	localparam int CW = $clog2(NW / 2 + 1);

	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [NW-1:0] load_c;
	logic [NW-1:0] num_c;
	logic [NW-1:0] quo_c;
	logic [DW-1:0] rem_c;

	assign load_c = num + NW'(den >> 1);

	always_comb begin
		logic [DW:0] t;
		num_c = num_q;
		quo_c = quo_q;
		rem_c = rem_q;
		for (int i = 0; i < 2; i++) begin
			t     = {rem_c, num_c[NW-1]};
			num_c = {num_c[NW-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t     = t - {1'b0, den_q};
				quo_c = {quo_c[NW-2:0], 1'b1};
			end else begin
				quo_c = {quo_c[NW-2:0], 1'b0};
			end
			rem_c = t[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				den_q <= den;
				rem_q <= '0;
				quo_q <= '0;
				if (short_sel) begin
					num_q <= load_c << (NW - 2 * SHORT_STEPS);
					cnt_q <= CW'(SHORT_STEPS);
				end else begin
					num_q <= load_c;
					cnt_q <= CW'(NW / 2);
				end
			end else if (cnt_q != '0) begin
				num_q <= num_c;
				quo_q <= quo_c;
				rem_q <= rem_c;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	`ASSERT_CLK(a_start_idle, clk, arst_n, start |-> cnt_q == '0)
	`ASSERT_CLK(a_done_idle, clk, arst_n, done_q |-> cnt_q == '0)
	`ASSERT_CLK(a_done_after_step, clk, arst_n, $rose(done_q) |-> $past(cnt_q) == CW'(1))

endmodule

`default_nettype wire

/* hdl/ptvs_lane.sv */
// ----------------------------------------------------------------------------
// ptvs_lane
// One axis: difference, scale to per-second, divide by step, box filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptvs_lane #(
	parameter int AVG_TAPS = ptvs_pkg::AVG_TAPS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  ptvs_pkg::lane_ctl_t                ctl,
	input  wire signed [ptvs_pkg::POS_W-1:0]   pos,
	input  wire signed [ptvs_pkg::POS_W-1:0]   prev,
	input  wire        [ptvs_pkg::DEN_W-1:0]   den,
	output logic                               done,
	output logic signed [ptvs_pkg::POS_W-1:0]  vel
);
	import ptvs_pkg::*;

	localparam int HIST_LEN    = AVG_TAPS - 1;
	localparam int SUMW        = POS_W + $clog2(AVG_TAPS);
	localparam int SHORT_STEPS = (SUMW + 1) / 2;
	localparam int DIFF_W      = POS_W + 1;

	typedef enum logic [2:0] {
		L_IDLE,
		L_MUL,
		L_DIV1,
		L_SUM,
		L_DIV2
	} lane_state_t;

	lane_state_t state_q;

	logic [DIFF_W-1:0]       mag_s1;
	logic                    neg_s1;
	logic signed [POS_W-1:0] raw_s3;
	logic                    neg_s4;
	logic signed [POS_W-1:0] hist_q [HIST_LEN];
	logic signed [SUMW-1:0]  hist_sum_q;
	logic signed [POS_W-1:0] vel_q;
	logic                    done_q;

	logic [NUM_W-1:0] div_num_q;
	logic [DEN_W-1:0] div_den_q;
	logic             div_start_q;
	logic             div_short_q;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;

	logic signed [DIFF_W-1:0] diff_c;
	logic signed [POS_W-1:0]  sat_c;
	logic signed [SUMW-1:0]   raw_ext_c;
	logic signed [SUMW-1:0]   old_ext_c;
	logic signed [SUMW-1:0]   sum_c;
	logic [SUMW-1:0]          sum_mag_c;
	logic [POS_W-1:0]         avg_c;

	assign diff_c = {pos[POS_W-1], pos} - {prev[POS_W-1], prev};

	// saturate the rounded magnitude to the signed field
	always_comb begin
		if (neg_s1) begin
			if (div_quo[NUM_W-1:POS_W] != '0
					|| (div_quo[POS_W-1] && div_quo[POS_W-2:0] != '0))
				sat_c = {1'b1, {(POS_W-1){1'b0}}};
			else
				sat_c = -$signed(div_quo[POS_W-1:0]);
		end else begin
			if (div_quo[NUM_W-1:POS_W-1] != '0)
				sat_c = {1'b0, {(POS_W-1){1'b1}}};
			else
				sat_c = $signed(div_quo[POS_W-1:0]);
		end
	end

	assign raw_ext_c = {{(SUMW-POS_W){raw_s3[POS_W-1]}}, raw_s3};
	assign old_ext_c = {{(SUMW-POS_W){hist_q[HIST_LEN-1][POS_W-1]}}, hist_q[HIST_LEN-1]};
	assign sum_c     = raw_ext_c + hist_sum_q;
	assign sum_mag_c = sum_c[SUMW-1] ? SUMW'(-sum_c) : SUMW'(sum_c);
	assign avg_c     = div_quo[POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= L_IDLE;
			mag_s1      <= '0;
			neg_s1      <= 1'b0;
			raw_s3      <= '0;
			neg_s4      <= 1'b0;
			hist_sum_q  <= '0;
			vel_q       <= '0;
			done_q      <= 1'b0;
			div_num_q   <= '0;
			div_den_q   <= '0;
			div_start_q <= 1'b0;
			div_short_q <= 1'b0;
			for (int k = 0; k < HIST_LEN; k++)
				hist_q[k] <= '0;
		end else begin
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (ctl.prime) begin
						hist_sum_q <= '0;
						for (int k = 0; k < HIST_LEN; k++)
							hist_q[k] <= '0;
					end
					if (ctl.start) begin
						neg_s1  <= diff_c[DIFF_W-1];
						mag_s1  <= diff_c[DIFF_W-1] ? DIFF_W'(-diff_c) : DIFF_W'(diff_c);
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					div_num_q   <= NUM_W'(mag_s1) * NUM_W'(US_PER_S);
					div_den_q   <= den;
					div_short_q <= 1'b0;
					div_start_q <= 1'b1;
					state_q     <= L_DIV1;
				end
				L_DIV1: begin
					if (div_done) begin
						raw_s3  <= sat_c;
						state_q <= L_SUM;
					end
				end
				L_SUM: begin
					neg_s4      <= sum_c[SUMW-1];
					div_num_q   <= NUM_W'(sum_mag_c);
					div_den_q   <= DEN_W'(AVG_TAPS);
					div_short_q <= 1'b1;
					div_start_q <= 1'b1;
					hist_sum_q  <= hist_sum_q + raw_ext_c - old_ext_c;
					for (int k = HIST_LEN - 1; k > 0; k--)
						hist_q[k] <= hist_q[k-1];
					hist_q[0]   <= raw_s3;
					state_q     <= L_DIV2;
				end
				L_DIV2: begin
					if (div_done) begin
						vel_q   <= neg_s4 ? -$signed(avg_c) : $signed(avg_c);
						done_q  <= 1'b1;
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	ptvs_div #(
		.NW          (NUM_W),
		.DW          (DEN_W),
		.SHORT_STEPS (SHORT_STEPS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.short_sel (div_short_q),
		.num       (div_num_q),
		.den       (div_den_q),
		.done      (div_done),
		.quo       (div_quo)
	);

	assign done = done_q;
	assign vel  = vel_q;

endmodule

`default_nettype wire

/* hdl/pose_to_velocity_smoother_unit.sv */
// ----------------------------------------------------------------------------
// pose_to_velocity_smoother_unit
// Velocity estimate from timestamped 3-axis positions, 5-tap box filtered.
// ----------------------------------------------------------------------------
// Input channel: pos_x/y/z (Q15.16 m) and stamp_us, one beat per sample,
// taken when in_valid is high and in_stall low. Output channel: the position
// passed through, vel_x/y/z (Q15.16 m/s), step_clamped and first_sample,
// one beat per input, taken when out_valid is high and out_stall low.
// cfg_we/cfg_wdata set min_step_us; write only while the block is idle.
// One sample is in work at a time. Three axis lanes run side by side; each
// uses a radix-4 divider twice, first by the time step, then by the tap
// count. The next beat can be taken the cycle after the result is loaded
// into the output register; no new sample is taken before that load.
// The priming sample after reset skips the lanes and goes straight to the
// output stage.
// Reset clears the primed flag, drops any result and sets min_step_us to
// 10000. A stalled output holds its beat and the block waits with it; the
// next input is accepted while that beat is still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pose_to_velocity_smoother_unit #(
	parameter int AVG_TAPS = ptvs_pkg::AVG_TAPS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire        [ptvs_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire signed [ptvs_pkg::POS_W-1:0]     pos_x,
	input  wire signed [ptvs_pkg::POS_W-1:0]     pos_y,
	input  wire signed [ptvs_pkg::POS_W-1:0]     pos_z,
	input  wire        [ptvs_pkg::STAMP_W-1:0]   stamp_us,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic signed [ptvs_pkg::POS_W-1:0]    out_pos_x,
	output logic signed [ptvs_pkg::POS_W-1:0]    out_pos_y,
	output logic signed [ptvs_pkg::POS_W-1:0]    out_pos_z,
	output logic signed [ptvs_pkg::POS_W-1:0]    vel_x,
	output logic signed [ptvs_pkg::POS_W-1:0]    vel_y,
	output logic signed [ptvs_pkg::POS_W-1:0]    vel_z,
	output logic                                 step_clamped,
	output logic                                 first_sample
);
	import ptvs_pkg::*;

	typedef enum logic [1:0] {
		T_IDLE,
		T_CALC,
		T_OUT
	} top_state_t;

	top_state_t state_q;

	logic [CFG_W-1:0]        min_step_q;
	logic                    primed_q;
	logic [STAMP_W-1:0]      prev_stamp_q;
	logic signed [POS_W-1:0] prev_q [N_AXES];
	logic signed [POS_W-1:0] pos_q [N_AXES];
	logic [DEN_W-1:0]        dt_q;
	logic                    clamp_q;
	logic                    first_q;

	logic signed [POS_W-1:0] out_pos_q [N_AXES];
	logic signed [POS_W-1:0] out_vel_q [N_AXES];
	logic                    out_valid_q;
	logic                    out_clamp_q;
	logic                    out_first_q;

	logic signed [POS_W-1:0] pos_in [N_AXES];
	logic signed [POS_W-1:0] lane_vel [N_AXES];
	logic [N_AXES-1:0]       lane_done;
	lane_ctl_t               lane_ctl;

	logic                    accept;
	logic                    out_load;
	logic [STAMP_W-1:0]      step_c;
	logic [DEN_W-1:0]        min_c;
	logic                    clamp_c;

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	assign in_stall = (state_q != T_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == T_OUT) && (!out_valid_q || !out_stall);

	assign lane_ctl.start = accept && primed_q;
	assign lane_ctl.prime = accept && !primed_q;

	// zero minimum acts as one microsecond
	assign step_c  = stamp_us - prev_stamp_q;
	assign min_c   = (min_step_q == '0) ? DEN_W'(1) : DEN_W'(min_step_q);
	assign clamp_c = $signed(step_c) < $signed(min_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			min_step_q   <= MIN_STEP_RESET;
			primed_q     <= 1'b0;
			prev_stamp_q <= '0;
			dt_q         <= '0;
			clamp_q      <= 1'b0;
			first_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_clamp_q  <= 1'b0;
			out_first_q  <= 1'b0;
			for (int a = 0; a < N_AXES; a++) begin
				prev_q[a]    <= '0;
				pos_q[a]     <= '0;
				out_pos_q[a] <= '0;
				out_vel_q[a] <= '0;
			end
		end else begin
			if (cfg_we)
				min_step_q <= cfg_wdata;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (in_valid) begin
						for (int a = 0; a < N_AXES; a++) begin
							pos_q[a]  <= pos_in[a];
							prev_q[a] <= pos_in[a];
						end
						prev_stamp_q <= stamp_us;
						primed_q     <= 1'b1;
						first_q      <= !primed_q;
						clamp_q      <= primed_q && clamp_c;
						dt_q         <= clamp_c ? min_c : DEN_W'(step_c);
						state_q      <= primed_q ? T_CALC : T_OUT;
					end
				end
				T_CALC: begin
					if (&lane_done)
						state_q <= T_OUT;
				end
				T_OUT: begin
					if (out_load) begin
						for (int a = 0; a < N_AXES; a++) begin
							out_pos_q[a] <= pos_q[a];
							out_vel_q[a] <= first_q ? '0 : lane_vel[a];
						end
						out_clamp_q <= clamp_q;
						out_first_q <= first_q;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	for (genvar g = 0; g < N_AXES; g++) begin : g_lane
		ptvs_lane #(
			.AVG_TAPS (AVG_TAPS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.pos    (pos_in[g]),
			.prev   (prev_q[g]),
			.den    (dt_q),
			.done   (lane_done[g]),
			.vel    (lane_vel[g])
		);
	end

	assign out_valid    = out_valid_q;
	assign out_pos_x    = out_pos_q[0];
	assign out_pos_y    = out_pos_q[1];
	assign out_pos_z    = out_pos_q[2];
	assign vel_x        = out_vel_q[0];
	assign vel_y        = out_vel_q[1];
	assign vel_z        = out_vel_q[2];
	assign step_clamped = out_clamp_q;
	assign first_sample = out_first_q;

	`ASSERT_CLK(a_lanes_in_step, clk, arst_n, (lane_done == '0) || (&lane_done))
	`ASSERT_CLK(a_done_in_calc, clk, arst_n, (|lane_done) |-> state_q == T_CALC)
	`ASSERT_CLK(a_out_from_load, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == T_OUT)
	`ASSERT_NEVER(a_first_clamped, clk, arst_n, out_valid_q && out_first_q && out_clamp_q)

endmodule

`default_nettype wire
